// File: hw/rtl/u8u16_pkg.sv
package u8u16_pkg;

   // result kinds as shown on the result channel
   typedef enum logic [1:0] {
      KIND_UNIT  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   // lead byte boundaries
   localparam logic [7:0] CONT_BASE = 8'h80;
   localparam logic [7:0] LEAD2     = 8'hC0;
   localparam logic [7:0] LEAD3     = 8'hE0;
   localparam logic [7:0] LEAD4     = 8'hF0;
   localparam logic [7:0] LEAD5     = 8'hF8;
   localparam logic [7:0] LEAD6     = 8'hFC;
   localparam logic [7:0] LEAD_BAD  = 8'hFE;

   localparam logic [31:0] PLANE1_BASE = 32'h0001_0000;
   localparam logic [31:0] SUPP_RANGE  = 32'h0010_0000;
   localparam logic [15:0] HIGH_SURR   = 16'hD800;
   localparam logic [15:0] LOW_SURR    = 16'hDC00;
   localparam logic [9:0]  SURR_MASK   = 10'h3FF;

   // work for one accepted byte: up to two code units and an optional
   // terminal result (end or error)
   typedef struct packed {
      logic [1:0]       n_results;
      logic [1:0]       n_units;
      logic [1:0][15:0] unit;
      logic [1:0][15:0] count;
      kind_type         term_kind;
      logic [15:0]      term_count;
   } job_type;

endpackage

// File: hw/rtl/u8u16_req_if.sv
interface u8u16_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_string;

   modport source (output valid, output data_byte, output end_of_string, input ready);
   modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

// File: hw/rtl/u8u16_rsp_if.sv
interface u8u16_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic [1:0]  result_kind;
   logic [15:0] units_so_far;
   logic        run_last;

   modport source (output valid, output code_unit, output result_kind,
                   output units_so_far, output run_last, input ready);
   modport sink   (input valid, input code_unit, input result_kind,
                   input units_so_far, input run_last, output ready);
endinterface

// File: hw/rtl/u8u16_front.sv
module u8u16_front import u8u16_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   u8u16_req_if.sink    req_bus,
   input  logic         q_full,
   output logic         push,
   output job_type      job
);

   localparam int DISP_W = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   logic [31:0]            pv_ff, pv_in;
   logic [2:0]             be_ff, be_in;
   logic                   halt_ff, halt_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;

   logic [7:0]             b;
   logic                   eos;
   logic                   accept;
   logic                   em, lit, lead_err, term, fail, big, bad;
   logic [31:0]            ev, w32;
   logic [1:0]             nu;
   logic [COUNT_WIDTH-1:0] c0, c1, cfin;

   assign b       = req_bus.data_byte;
   assign eos     = req_bus.end_of_string;
   assign req_bus.ready = !q_full;
   assign accept  = req_bus.valid && !q_full;

   // decode one byte against the sequence state
   always_comb begin
      pv_in    = pv_ff;
      be_in    = be_ff;
      em       = 1'b0;
      ev       = pv_ff;
      lit      = 1'b0;
      lead_err = 1'b0;
      term     = 1'b0;
      if (halt_ff) begin
         term = 1'b0;
      end else if (b == 8'h00) begin
         em   = (be_ff != 3'd0);
         term = 1'b1;
      end else begin
         if (be_ff == 3'd0) begin
            if (!b[7]) begin
               lit = 1'b1;
            end else if (b < LEAD2 || b >= LEAD_BAD) begin
               lead_err = 1'b1;
            end else if (b < LEAD3) begin
               pv_in = 32'(b - LEAD2);
               be_in = 3'd1;
            end else if (b < LEAD4) begin
               pv_in = 32'(b - LEAD3);
               be_in = 3'd2;
            end else if (b < LEAD5) begin
               pv_in = 32'(b - LEAD4);
               be_in = 3'd3;
            end else if (b < LEAD6) begin
               pv_in = 32'(b - LEAD5);
               be_in = 3'd4;
            end else begin
               pv_in = 32'(b - LEAD6);
               be_in = 3'd5;
            end
         end else if (b >= CONT_BASE && b < LEAD2) begin
            pv_in = {pv_ff[25:0], b[5:0]};
            be_in = be_ff - 3'd1;
            if (be_in == 3'd0) begin
               em = 1'b1;
               ev = pv_in;
            end
         end else begin
            // bad continuation: byte dropped, partial value goes out
            be_in = 3'd0;
            em    = 1'b1;
         end
         if (eos && !lead_err && be_in != 3'd0) begin
            be_in = 3'd0;
            em    = 1'b1;
            ev    = pv_in;
         end
         term = eos;
      end
   end

   assign w32  = ev - PLANE1_BASE;
   assign big  = (ev >= PLANE1_BASE);
   assign bad  = em && big && (w32 >= SUPP_RANGE);
   assign fail = lead_err || bad;

   always_comb begin
      if (lit || (em && !big)) begin
         nu = 2'd1;
      end else if (em && big && !bad) begin
         nu = 2'd2;
      end else begin
         nu = 2'd0;
      end
   end

   assign c0   = (cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + 1'b1;
   assign c1   = (c0 == CNT_MAX) ? c0 : c0 + 1'b1;
   assign cfin = (nu == 2'd0) ? cnt_ff : ((nu == 2'd1) ? c0 : c1);

   always_comb begin
      halt_in = halt_ff;
      cnt_in  = cfin;
      if (halt_ff) begin
         if (b == 8'h00 || eos) begin
            halt_in = 1'b0;
            cnt_in  = '0;
         end else begin
            cnt_in  = cnt_ff;
         end
      end else if (term) begin
         cnt_in = '0;
      end else if (fail) begin
         halt_in = 1'b1;
      end
   end

   always_comb begin
      job.n_units    = nu;
      job.n_results  = nu + {1'b0, (fail || term)};
      if (lit) begin
         job.unit[0] = {8'h00, b};
      end else if (big) begin
         job.unit[0] = HIGH_SURR + {6'd0, w32[19:10]};
      end else begin
         job.unit[0] = ev[15:0];
      end
      job.unit[1]    = LOW_SURR + {6'd0, w32[9:0] & SURR_MASK};
      job.count[0]   = 16'(c0[DISP_W-1:0]);
      job.count[1]   = 16'(c1[DISP_W-1:0]);
      job.term_kind  = fail ? KIND_ERROR : KIND_END;
      job.term_count = 16'(cfin[DISP_W-1:0]);
   end

   assign push = accept && !halt_ff && (job.n_results != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff   <= '0;
         be_ff   <= '0;
         halt_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (accept) begin
         halt_ff <= halt_in;
         cnt_ff  <= cnt_in;
         if (halt_ff || term || fail) begin
            pv_ff <= '0;
            be_ff <= '0;
         end else begin
            pv_ff <= pv_in;
            be_ff <= be_in;
         end
      end
   end

endmodule

// File: hw/rtl/u8u16_queue.sv
module u8u16_queue import u8u16_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type wr_job,
   input  logic    pop,
   output logic    full,
   output logic    q_valid,
   output job_type rd_job
);

   localparam int DEPTH = 2;

   job_type    mem_ff [DEPTH];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign full    = (count_ff == 2'(DEPTH));
   assign q_valid = (count_ff != 2'd0);
   assign rd_job  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("push into full job queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid) else $error("pop from empty job queue");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff == $past(count_ff) + $past(2'(push)) - $past(2'(pop)))
      else $error("job queue count out of step");
`endif

endmodule

// File: hw/rtl/u8u16_back.sv
module u8u16_back import u8u16_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  job_type     rd_job,
   output logic        pop,
   u8u16_rsp_if.source rsp_bus
);

   logic        rsp_valid_ff;
   logic [15:0] unit_ff;
   kind_type    kind_ff;
   logic [15:0] count_ff;
   logic        last_ff;
   logic [1:0]  idx_ff;

   logic        out_free, load, last;
   logic [15:0] sel_unit, sel_count;
   kind_type    sel_kind;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign load     = out_free && q_valid;
   assign last     = (idx_ff == rd_job.n_results - 2'd1);
   assign pop      = load && last;

   always_comb begin
      if (idx_ff < rd_job.n_units) begin
         sel_unit  = rd_job.unit[idx_ff[0]];
         sel_count = rd_job.count[idx_ff[0]];
         sel_kind  = KIND_UNIT;
      end else begin
         sel_unit  = '0;
         sel_count = rd_job.term_count;
         sel_kind  = rd_job.term_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= q_valid;
         end
         if (load) begin
            idx_ff <= last ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         unit_ff  <= sel_unit;
         kind_ff  <= sel_kind;
         count_ff <= sel_count;
         last_ff  <= last;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.code_unit    = unit_ff;
   assign rsp_bus.result_kind  = kind_ff;
   assign rsp_bus.units_so_far = count_ff;
   assign rsp_bus.run_last     = last_ff;

`ifndef SYNTHESIS
   a_term_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff != KIND_UNIT |-> last_ff)
      else $error("terminal result not last of its beat");
   a_mid_job_held: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 2'd0 |-> q_valid && idx_ff < rd_job.n_results)
      else $error("result index outside current job");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff) else $error("output not empty after reset");
`endif

endmodule

// File: hw/rtl/utf8_to_utf16_decoder_core.sv
// UTF-8 to UTF-16 decoder core.
// req_bus carries one UTF-8 byte per beat with an end_of_string flag;
// rsp_bus carries results: a code unit, an end marker or an error, with
// the running unit count and run_last on the final result of each byte.
// A front stage decodes each byte against the sequence state and posts
// a job (up to two units plus an optional end/error) into a two-entry
// queue; a back stage drains jobs into an output register, one result per
// cycle while that register is free.
// A byte's results pass through the queue and then the output register.
// Throughput: one byte per cycle while the receiver is ready and each
// byte yields at most one result; a surrogate pair plus an end marker
// makes three results, and the output's one result per cycle sets the rate.
// Receiver stall: the output register holds, the queue fills and req
// ready drops once both queue entries are taken; nothing is dropped.
// Reset (synchronous): clears sequence state, halt flag, unit counter,
// queue and output valid flag.
module utf8_to_utf16_decoder_core import u8u16_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   u8u16_req_if.sink   req_bus,
   u8u16_rsp_if.source rsp_bus
);

   logic    push, pop, q_full, q_valid;
   job_type wr_job, rd_job;

   u8u16_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_full  (q_full),
      .push    (push),
      .job     (wr_job)
   );

   u8u16_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_job  (wr_job),
      .pop     (pop),
      .full    (q_full),
      .q_valid (q_valid),
      .rd_job  (rd_job)
   );

   u8u16_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .rd_job  (rd_job),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

// File: dv/tb_top.sv
module tb_top import u8u16_pkg::*; ();

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 200;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PHASE_BYTES    = 77;
   localparam int N_PHASES       = 4;
   localparam int N_ROWS         = 26;

   localparam int SEND_IDLE [N_PHASES] = '{0, 66, 0, 27};
   localparam int RX_STALL  [N_PHASES] = '{0, 0, 66, 27};

   typedef struct packed {
      logic [15:0] code_unit;
      kind_type    result_kind;
      logic [15:0] units_so_far;
      logic        run_last;
   } u16_result_type;

   // typed = 1: the row carries its own expectation (at most one result)
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        eos;
      logic        typed;
      logic        has_result;
      logic [15:0] code_unit;
      kind_type    result_kind;
      logic [15:0] units_so_far;
   } stim_row_type;

   localparam stim_row_type DIRECTED_ROWS [N_ROWS] = '{
      '{8'h41, 1'b0, 1'b1, 1'b1, 16'h0041, KIND_UNIT,  16'd1},
      '{8'h7F, 1'b0, 1'b1, 1'b1, 16'h007F, KIND_UNIT,  16'd2},
      '{8'hC3, 1'b0, 1'b1, 1'b0, 16'h0000, KIND_UNIT,  16'd0},
      '{8'hA9, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_UNIT,  16'd0},
      '{8'hF0, 1'b0, 1'b1, 1'b0, 16'h0000, KIND_UNIT,  16'd0},
      '{8'h9F, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_UNIT,  16'd0},
      '{8'h98, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_UNIT,  16'd0},
      '{8'h80, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_UNIT,  16'd0},
      // encoded surrogate value passes through as a single unit
      '{8'hED, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_UNIT,  16'd0},
      '{8'hA0, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_UNIT,  16'd0},
      '{8'h80, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_UNIT,  16'd0},
      // bad continuation is swallowed, partial value comes out
      '{8'hE4, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_UNIT,  16'd0},
      '{8'h41, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_UNIT,  16'd0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_UNIT,  16'd0},
      // lone continuation, then halted until the last flag
      '{8'h80, 1'b0, 1'b1, 1'b1, 16'h0000, KIND_ERROR, 16'd0},
      '{8'h41, 1'b1, 1'b1, 1'b0, 16'h0000, KIND_UNIT,  16'd0},
      // invalid leads
      '{8'hFF, 1'b1, 1'b1, 1'b1, 16'h0000, KIND_ERROR, 16'd0},
      '{8'hFE, 1'b0, 1'b1, 1'b1, 16'h0000, KIND_ERROR, 16'd0},
      '{8'h00, 1'b1, 1'b1, 1'b0, 16'h0000, KIND_UNIT,  16'd0},
      // 0x110000 on the last byte
      '{8'hF4, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_UNIT,  16'd0},
      '{8'h90, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_UNIT,  16'd0},
      '{8'h80, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_UNIT,  16'd0},
      '{8'h80, 1'b1, 1'b0, 1'b0, 16'h0000, KIND_UNIT,  16'd0},
      // six-byte lead cut short by the last flag
      '{8'hFC, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_UNIT,  16'd0},
      '{8'hBF, 1'b0, 1'b0, 1'b0, 16'h0000, KIND_UNIT,  16'd0},
      '{8'h80, 1'b1, 1'b0, 1'b0, 16'h0000, KIND_UNIT,  16'd0}
   };

   logic clock = 1'b0;
   logic reset;
   logic hold_rx = 1'b0;
   int   send_idle_pct = 0;
   int   rx_stall_pct = 0;
   int   error_count = 0;
   int   bytes_fed = 0;
   int   quiet_cycles = 0;

   // decoder state as predicted
   logic [31:0] seq_value;
   logic [2:0]  seq_left;
   logic        seq_halted;
   logic [15:0] unit_count;

   u16_result_type step_results [$];
   u16_result_type due_results [$];
   logic [7:0]     str_bytes [$];

   u8u16_req_if req_bus ();
   u8u16_rsp_if rsp_bus ();

   utf8_to_utf16_decoder_core #(.COUNT_WIDTH(16)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   function automatic void clear_string();
      seq_value  = 32'h0;
      seq_left   = 3'd0;
      seq_halted = 1'b0;
      unit_count = 16'h0;
   endfunction

   function automatic void put_result(logic [15:0] unit, kind_type kind);
      u16_result_type res;
      if (kind == KIND_UNIT && unit_count != 16'hFFFF) unit_count++;
      res.code_unit    = (kind == KIND_UNIT) ? unit : 16'h0;
      res.result_kind  = kind;
      res.units_so_far = unit_count;
      res.run_last     = 1'b0;
      step_results = {step_results, res};
   endfunction

   // one or two units; 0 when the value is beyond the supplementary planes
   function automatic logic emit_code_point(logic [31:0] cp);
      logic [31:0] v;
      if (cp < PLANE1_BASE) begin
         put_result(cp[15:0], KIND_UNIT);
         return 1'b1;
      end
      v = cp - PLANE1_BASE;
      if (v >= SUPP_RANGE) return 1'b0;
      put_result(HIGH_SURR + 16'(v >> 10), KIND_UNIT);
      put_result(LOW_SURR + {6'd0, v[9:0] & SURR_MASK}, KIND_UNIT);
      return 1'b1;
   endfunction

   function automatic void decode_byte(logic [7:0] b, logic eos);
      logic ok;
      ok = 1'b1;
      step_results.delete();
      if (seq_halted) begin
         if (b == 8'h00 || eos) clear_string();
         return;
      end
      if (b == 8'h00) begin
         if (seq_left != 3'd0) begin
            seq_left = 3'd0;
            ok = emit_code_point(seq_value);
         end
         put_result(16'h0, ok ? KIND_END : KIND_ERROR);
         clear_string();
      end else begin
         if (seq_left == 3'd0) begin
            if (b < CONT_BASE) begin
               put_result({8'h00, b}, KIND_UNIT);
            end else if (b < LEAD2 || b >= LEAD_BAD) begin
               ok = 1'b0;
            end else if (b < LEAD3) begin
               seq_value = {24'h0, b - LEAD2};
               seq_left  = 3'd1;
            end else if (b < LEAD4) begin
               seq_value = {24'h0, b - LEAD3};
               seq_left  = 3'd2;
            end else if (b < LEAD5) begin
               seq_value = {24'h0, b - LEAD4};
               seq_left  = 3'd3;
            end else if (b < LEAD6) begin
               seq_value = {24'h0, b - LEAD5};
               seq_left  = 3'd4;
            end else begin
               seq_value = {24'h0, b - LEAD6};
               seq_left  = 3'd5;
            end
         end else if (b >= CONT_BASE && b < LEAD2) begin
            seq_value = {seq_value[25:0], b[5:0]};
            seq_left  = seq_left - 3'd1;
            if (seq_left == 3'd0) ok = emit_code_point(seq_value);
         end else begin
            seq_left = 3'd0;
            ok = emit_code_point(seq_value);
         end
         if (ok && eos && seq_left != 3'd0) begin
            seq_left = 3'd0;
            ok = emit_code_point(seq_value);
         end
         if (!ok) begin
            put_result(16'h0, KIND_ERROR);
            if (eos) begin
               clear_string();
            end else begin
               seq_halted = 1'b1;
               seq_value  = 32'h0;
               seq_left   = 3'd0;
            end
         end else if (eos) begin
            put_result(16'h0, KIND_END);
            clear_string();
         end
      end
      if (step_results.size() > 0) step_results[step_results.size() - 1].run_last = 1'b1;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   // returns at the edge where the byte's beat is taken
   task automatic send_byte(logic [7:0] b, logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.data_byte     <= b;
      req_bus.end_of_string <= eos;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic feed_byte(logic [7:0] b, logic eos);
      send_byte(b, eos);
      decode_byte(b, eos);
      foreach (step_results[i]) due_results = {due_results, step_results[i]};
      bytes_fed++;
   endtask

   // mostly well-formed characters, with noise bytes and cut sequences
   task automatic feed_random_string();
      int          n_chars;
      int          pick;
      int          len;
      int          keep;
      int          term;
      logic [31:0] cp;
      logic [7:0]  prefix;
      str_bytes.delete();
      n_chars = $urandom_range(10);
      for (int c = 0; c < n_chars; c++) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            str_bytes = {str_bytes, 8'($urandom_range(255))};
            continue;
         end
         if (pick < 30)      len = 1;
         else if (pick < 50) len = 2;
         else if (pick < 70) len = 3;
         else if (pick < 92) len = 4;
         else if (pick < 96) len = 5;
         else                len = 6;
         case (len)
            1: cp = 32'($urandom_range(8'h7F, 1));
            2: cp = $urandom & 32'h0000_07FF;
            3: cp = $urandom & 32'h0000_FFFF;
            4: cp = ($urandom_range(7) == 0) ? ($urandom & 32'h001F_FFFF)
                                              : 32'($urandom_range(32'h0010_FFFF));
            5: cp = $urandom & 32'h03FF_FFFF;
            default: cp = $urandom & 32'h7FFF_FFFF;
         endcase
         case (len)
            2: prefix = LEAD2;
            3: prefix = LEAD3;
            4: prefix = LEAD4;
            5: prefix = LEAD5;
            default: prefix = LEAD6;
         endcase
         if (len == 1) begin
            str_bytes = {str_bytes, cp[7:0]};
            continue;
         end
         keep = ($urandom_range(19) == 0) ? $urandom_range(len - 2) : len - 1;
         str_bytes = {str_bytes, prefix | 8'(cp >> (6 * (len - 1)))};
         for (int k = len - 2; k >= len - 1 - keep; k--)
            str_bytes = {str_bytes, CONT_BASE | {2'b00, 6'(cp >> (6 * k))}};
      end
      term = $urandom_range(3);
      if (term < 2 || str_bytes.size() == 0) str_bytes = {str_bytes, 8'h00};
      foreach (str_bytes[i])
         feed_byte(str_bytes[i],
                   (i == str_bytes.size() - 1) && (term != 0 || str_bytes[i] != 8'h00));
   endtask

   always @(posedge clock) begin : rsp_check
      u16_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (due_results.size() == 0) begin
               report_mismatch("result with nothing due", rsp_bus.result_kind, 0);
            end else begin
               want = due_results.pop_front();
               if (rsp_bus.code_unit !== want.code_unit)
                  report_mismatch("code_unit", rsp_bus.code_unit, want.code_unit);
               if (rsp_bus.result_kind !== want.result_kind)
                  report_mismatch("result_kind", rsp_bus.result_kind, want.result_kind);
               if (rsp_bus.units_so_far !== want.units_so_far)
                  report_mismatch("units_so_far", rsp_bus.units_so_far, want.units_so_far);
               if (rsp_bus.run_last !== want.run_last)
                  report_mismatch("run_last", rsp_bus.run_last, want.run_last);
            end
         end
         rsp_bus.ready <= !hold_rx && ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: %0d cycles without a beat, %0d results outstanding",
                  quiet_cycles, due_results.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      stim_row_type   row;
      u16_result_type typed_res;
      int             phase_start;
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.data_byte     <= 8'h00;
      req_bus.end_of_string <= 1'b0;
      clear_string();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         row = DIRECTED_ROWS[i];
         if (!row.typed) begin
            feed_byte(row.data_byte, row.eos);
         end else begin
            send_byte(row.data_byte, row.eos);
            decode_byte(row.data_byte, row.eos);
            if (row.has_result) begin
               typed_res = '{row.code_unit, row.result_kind, row.units_so_far, 1'b1};
               due_results = {due_results, typed_res};
            end
         end
      end

      for (int p = 0; p < N_PHASES; p++) begin
         send_idle_pct = SEND_IDLE[p];
         rx_stall_pct  = RX_STALL[p];
         // long receiver hold-off while bytes keep coming: backs up into req ready
         if (p == 0) begin
            fork
               begin
                  hold_rx <= 1'b1;
                  repeat (HOLD_CYCLES) @(posedge clock);
                  hold_rx <= 1'b0;
               end
            join_none
         end
         phase_start = bytes_fed;
         while (bytes_fed - phase_start < PHASE_BYTES) feed_random_string();
      end
      req_bus.valid <= 1'b0;

      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: utf8_to_utf16_decoder_core.f
hw/rtl/u8u16_pkg.sv
hw/rtl/u8u16_req_if.sv
hw/rtl/u8u16_rsp_if.sv
hw/rtl/u8u16_front.sv
hw/rtl/u8u16_queue.sv
hw/rtl/u8u16_back.sv
hw/rtl/utf8_to_utf16_decoder_core.sv
dv/tb_top.sv
